// ===== sv/lfsa_pkg.sv =====
package lfsa_pkg;

    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RMW,
        S_SCAN,
        S_SCAN_LOAD
    } state_t;

    typedef enum logic [1:0] {
        K_TOP,
        K_LIST,
        K_FREE
    } kind_t;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
    } ffs_t;

endpackage

// ===== sv/lfsa_flag_ram.sv =====
module lfsa_flag_ram #(
    parameter int ROWS  = 8,
    parameter int ROW_W = 3
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [ROW_W-1:0]           wr_addr,
    input  logic [lfsa_pkg::WORD_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [ROW_W-1:0]           rd_addr,
    output logic [lfsa_pkg::WORD_W-1:0] rd_data
);

    logic [lfsa_pkg::WORD_W-1:0] mem [ROWS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/lfsa_first_set.sv =====
module lfsa_first_set (
    input  logic [lfsa_pkg::WORD_W-1:0] word,
    output lfsa_pkg::ffs_t              res
);

    always_comb begin
        res.found = 1'b0;
        res.pos   = '0;
        for (int i = lfsa_pkg::WORD_W - 1; i >= 0; i--) begin
            if (word[i]) begin
                res.found = 1'b1;
                res.pos   = lfsa_pkg::BIT_W'(i);
            end
        end
    end

endmodule

// ===== sv/lowest_free_slot_allocator_unit.sv =====
// flow: a full table or a free at or above the high-water mark is answered from idle; other
// requests pass through the read-modify-write state, and a rescanning allocate also loops
// through the scan and scan-load states; throughput: one item at a time, the rescan walking
// one 32-bit flag word per loop through the flag memory and the first-set finder
// reset: synchronous active-low aresetn clears counters, pointer and handshake state;
// the flag memory is not cleared, entries at or above the high-water mark read as zero
module lowest_free_slot_allocator_unit #(
    parameter int SLOTS = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // slot_in
    input  logic       s_tuser,   // op
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // slot_out
    output logic [1:0] m_tuser    // status
);

    localparam int WORD_W = lfsa_pkg::WORD_W;
    localparam int BIT_W  = lfsa_pkg::BIT_W;
    localparam int ROWS   = (SLOTS + WORD_W - 1) / WORD_W;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W  = ROW_W + BIT_W;
    localparam int HW_W   = $clog2(SLOTS + 1);
    localparam int XW0    = (IDX_W > HW_W) ? IDX_W : HW_W;
    localparam int XW     = (XW0 > 8) ? XW0 : 8;

    lfsa_pkg::state_t state_reg, state_next;
    lfsa_pkg::kind_t  kind_reg, kind_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [HW_W-1:0]   high_water_reg, high_water_next;
    logic [HW_W-1:0]   free_total_reg, free_total_next;
    logic [IDX_W-1:0]  lowest_free_reg, lowest_free_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [7:0]        m_slot_reg, m_slot_next;
    logic [1:0]        m_status_reg, m_status_next;

    logic              wr_en;
    logic [ROW_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [ROW_W-1:0]  rd_addr;
    logic [WORD_W-1:0] rd_data;

    lfsa_pkg::ffs_t    ffs;

    logic              accept;
    logic [XW-1:0]     hw_x;
    logic [XW-1:0]     row_x;
    logic [XW-1:0]     hw_row_x;
    logic [XW-1:0]     last_row_x;
    logic [WORD_W-1:0] valid_mask;
    logic [WORD_W-1:0] masked;
    logic [WORD_W-1:0] onehot;
    logic [IDX_W-1:0]  slot_idx;
    logic [HW_W-1:0]   ft_dec;

    lfsa_flag_ram #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lfsa_first_set u_ffs (
        .word (word_reg),
        .res  (ffs)
    );

    assign s_tready = (state_reg == lfsa_pkg::S_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_slot_reg;
    assign m_tuser  = m_status_reg;

    // bits of the current row that lie below the high-water mark
    assign hw_x       = XW'(high_water_reg);
    assign row_x      = XW'(row_reg);
    assign hw_row_x   = hw_x >> BIT_W;
    assign last_row_x = (hw_x - XW'(1)) >> BIT_W;

    always_comb begin
        if (row_x < hw_row_x) begin
            valid_mask = '1;
        end else if (row_x == hw_row_x) begin
            valid_mask = (WORD_W'(1) << hw_x[BIT_W-1:0]) - WORD_W'(1);
        end else begin
            valid_mask = '0;
        end
    end

    assign masked   = rd_data & valid_mask;
    assign onehot   = WORD_W'(1) << idx_reg[BIT_W-1:0];
    assign slot_idx = IDX_W'(XW'(s_tdata));
    assign ft_dec   = free_total_reg - HW_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= lfsa_pkg::S_IDLE;
            high_water_reg  <= '0;
            free_total_reg  <= '0;
            lowest_free_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            high_water_reg  <= high_water_next;
            free_total_reg  <= free_total_next;
            lowest_free_reg <= lowest_free_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        idx_reg      <= idx_next;
        row_reg      <= row_next;
        word_reg     <= word_next;
        m_slot_reg   <= m_slot_next;
        m_status_reg <= m_status_next;
    end

    always_comb begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        idx_next         = idx_reg;
        row_next         = row_reg;
        word_next        = word_reg;
        high_water_next  = high_water_reg;
        free_total_next  = free_total_reg;
        lowest_free_next = lowest_free_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_slot_next      = m_slot_reg;
        m_status_next    = m_status_reg;
        wr_en            = 1'b0;
        wr_addr          = row_reg;
        wr_data          = '0;
        rd_en            = 1'b0;
        rd_addr          = row_reg;

        unique case (state_reg)
            lfsa_pkg::S_IDLE: begin
                if (accept) begin
                    if (s_tuser == lfsa_pkg::OP_ALLOC) begin
                        if (free_total_reg != '0) begin
                            kind_next  = lfsa_pkg::K_LIST;
                            idx_next   = lowest_free_reg;
                            state_next = lfsa_pkg::S_RMW;
                        end else if (high_water_reg == HW_W'(SLOTS)) begin
                            m_tvalid_next = 1'b1;
                            m_slot_next   = '0;
                            m_status_next = lfsa_pkg::ST_FULL;
                        end else begin
                            kind_next  = lfsa_pkg::K_TOP;
                            idx_next   = IDX_W'(hw_x);
                            state_next = lfsa_pkg::S_RMW;
                        end
                    end else begin
                        if (XW'(s_tdata) >= hw_x) begin
                            m_tvalid_next = 1'b1;
                            m_slot_next   = '0;
                            m_status_next = lfsa_pkg::ST_IGNORED;
                        end else begin
                            kind_next  = lfsa_pkg::K_FREE;
                            idx_next   = slot_idx;
                            state_next = lfsa_pkg::S_RMW;
                        end
                    end
                    row_next = idx_next[IDX_W-1:BIT_W];
                    rd_en    = 1'b1;
                    rd_addr  = row_next;
                end
            end
            lfsa_pkg::S_RMW: begin
                state_next    = lfsa_pkg::S_IDLE;
                m_slot_next   = '0;
                m_status_next = lfsa_pkg::ST_DONE;
                m_tvalid_next = 1'b1;
                unique case (kind_reg)
                    lfsa_pkg::K_TOP: begin
                        wr_en           = 1'b1;
                        wr_data         = masked & ~onehot;
                        high_water_next = high_water_reg + HW_W'(1);
                        m_slot_next     = 8'(XW'(idx_reg));
                    end
                    lfsa_pkg::K_LIST: begin
                        wr_en           = 1'b1;
                        wr_data         = masked & ~onehot;
                        free_total_next = ft_dec;
                        m_slot_next     = 8'(XW'(idx_reg));
                        if (ft_dec != '0) begin
                            // rescan from the slot above the one handed out
                            word_next     = wr_data & ~((onehot << 1) - WORD_W'(1));
                            m_tvalid_next = 1'b0;
                            state_next    = lfsa_pkg::S_SCAN;
                        end
                    end
                    lfsa_pkg::K_FREE: begin
                        if ((masked & onehot) != '0) begin
                            m_status_next = lfsa_pkg::ST_IGNORED;
                        end else begin
                            wr_en           = 1'b1;
                            wr_data         = masked | onehot;
                            free_total_next = free_total_reg + HW_W'(1);
                            if (free_total_reg == '0 || lowest_free_reg > idx_reg) begin
                                lowest_free_next = idx_reg;
                            end
                        end
                    end
                    default: begin
                        m_status_next = lfsa_pkg::ST_DONE;
                    end
                endcase
            end
            lfsa_pkg::S_SCAN: begin
                if (ffs.found) begin
                    lowest_free_next = {row_reg, ffs.pos};
                    m_tvalid_next    = 1'b1;
                    state_next       = lfsa_pkg::S_IDLE;
                end else if (row_x >= last_row_x) begin
                    m_tvalid_next = 1'b1;
                    state_next    = lfsa_pkg::S_IDLE;
                end else begin
                    row_next   = ROW_W'(row_reg + ROW_W'(1));
                    rd_en      = 1'b1;
                    rd_addr    = row_next;
                    state_next = lfsa_pkg::S_SCAN_LOAD;
                end
            end
            lfsa_pkg::S_SCAN_LOAD: begin
                word_next  = masked;
                state_next = lfsa_pkg::S_SCAN;
            end
            default: begin
                state_next = lfsa_pkg::S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_free_le_hw: assert property (@(posedge aclk) disable iff (!aresetn)
        free_total_reg <= high_water_reg)
        else $error("free count above high-water mark");

    a_hw_le_slots: assert property (@(posedge aclk) disable iff (!aresetn)
        XW'(high_water_reg) <= XW'(SLOTS))
        else $error("high-water mark beyond table");

    a_lowest_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (free_total_reg != '0) |-> (XW'(lowest_free_reg) < hw_x))
        else $error("lowest free slot not below high-water mark");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> (!m_tvalid || m_tready))
        else $error("item accepted while result still pending");
`endif

endmodule

// ===== verif/slot_grant_checker.sv =====
`timescale 1ns / 1ps

module slot_grant_checker #(
    parameter int SLOTS = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // slot_in
    input  logic       s_tuser,   // op
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // slot_out
    input  logic [1:0] m_tuser,   // status
    output int         mismatches,
    output int         pending
);

    typedef struct packed {
        logic [7:0] slot;
        logic [1:0] status;
    } grant_t;

    logic       slot_freed [SLOTS];
    logic [8:0] mark;
    logic [8:0] freed_cnt;
    logic [7:0] lowest_freed;

    grant_t grant_q[$];
    int     err_cnt;

    function automatic grant_t serve_request(logic op, logic [7:0] idx);
        grant_t g;
        g.slot   = '0;
        g.status = lfsa_pkg::ST_DONE;
        if (op == lfsa_pkg::OP_ALLOC) begin
            if (freed_cnt == 0) begin
                if (mark >= SLOTS) begin
                    g.status = lfsa_pkg::ST_FULL;
                end else begin
                    g.slot = mark[7:0];
                    slot_freed[mark[7:0]] = 1'b0;
                    mark = mark + 9'd1;
                end
            end else begin
                g.slot = lowest_freed;
                slot_freed[lowest_freed] = 1'b0;
                freed_cnt = freed_cnt - 9'd1;
                if (freed_cnt != 0) begin
                    // rescan upward below the mark for the next freed slot
                    for (int i = int'(g.slot) + 1; i < int'(mark) && i < SLOTS; i++) begin
                        if (slot_freed[i]) begin
                            lowest_freed = i[7:0];
                            break;
                        end
                    end
                end
            end
        end else begin
            if ({1'b0, idx} >= mark || slot_freed[idx]) begin
                g.status = lfsa_pkg::ST_IGNORED;
            end else begin
                slot_freed[idx] = 1'b1;
                freed_cnt = freed_cnt + 9'd1;
                if (freed_cnt == 9'd1 || lowest_freed > idx)
                    lowest_freed = idx;
            end
        end
        return g;
    endfunction

    always @(posedge aclk) begin
        grant_t want;
        if (!aresetn) begin
            for (int k = 0; k < SLOTS; k++)
                slot_freed[k] = 1'b0;
            mark         = '0;
            freed_cnt    = '0;
            lowest_freed = '0;
            grant_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                grant_q.push_back(serve_request(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                if (grant_q.size() == 0) begin
                    $error("unexpected item: slot_out %0d status %0d", m_tdata, m_tuser);
                    err_cnt++;
                end else begin
                    want = grant_q.pop_front();
                    if (m_tdata !== want.slot) begin
                        $error("slot_out: expected %0d, got %0d", want.slot, m_tdata);
                        err_cnt++;
                    end
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        err_cnt++;
                    end
                end
            end
        end
        pending    <= grant_q.size();
        mismatches <= err_cnt;
    end

endmodule

// ===== verif/lowest_free_slot_allocator_unit_tb.sv =====
`timescale 1ns / 1ps

module lowest_free_slot_allocator_unit_tb;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;

    int mismatches;
    int pending;
    int sent_cnt;

    always #10 aclk = ~aclk;

    lowest_free_slot_allocator_unit #(
        .SLOTS(256)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    slot_grant_checker #(
        .SLOTS(256)
    ) u_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .mismatches(mismatches),
        .pending   (pending)
    );

    task automatic send_request(input logic op, input logic [7:0] idx);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= idx;
        do @(posedge aclk); while (!s_tready);
        sent_cnt++;
    endtask

    task automatic idle_between();
        int r;
        r = $urandom_range(0, 99);
        if (r >= 55) begin
            s_tvalid <= 1'b0;
            if (r < 92)
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            else
                repeat ($urandom_range(8, 40)) @(posedge aclk);
        end
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic run_phase(input int len, input int alloc_pct, input bit no_gaps);
        logic       op;
        logic [7:0] idx;
        for (int n = 0; n < len; n++) begin
            op  = ($urandom_range(0, 99) < alloc_pct) ? lfsa_pkg::OP_ALLOC
                                                      : lfsa_pkg::OP_FREE;
            idx = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 15))
                                              : 8'($urandom_range(0, 255));
            send_request(op, idx);
            if (!no_gaps)
                idle_between();
        end
    endtask

    // result side: random stalls, ready stretches, one long hold-off during the fill
    initial begin
        bit held;
        int r;
        held     = 1'b0;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            r = $urandom_range(0, 99);
            if (!held && sent_cnt >= 100) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (200) @(posedge aclk);
            end else if (r < 55) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else if (r < 85) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else if (r < 95) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(8, 40)) @(posedge aclk);
            end
        end
    end

    initial begin
        int kind;
        int pct;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = lfsa_pkg::OP_ALLOC;
        sent_cnt = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: first grants, double free, frees above the mark, rescan, top grant
        send_request(lfsa_pkg::OP_ALLOC, 8'hFF);   idle_between();
        send_request(lfsa_pkg::OP_FREE,  8'd0);    idle_between();
        send_request(lfsa_pkg::OP_FREE,  8'd0);    idle_between();
        send_request(lfsa_pkg::OP_ALLOC, 8'h00);   idle_between();
        send_request(lfsa_pkg::OP_ALLOC, 8'hA5);   idle_between();
        send_request(lfsa_pkg::OP_ALLOC, 8'h5A);   idle_between();
        send_request(lfsa_pkg::OP_ALLOC, 8'h00);   idle_between();
        send_request(lfsa_pkg::OP_FREE,  8'd255);  idle_between();
        send_request(lfsa_pkg::OP_FREE,  8'd4);    idle_between();
        send_request(lfsa_pkg::OP_FREE,  8'd2);    idle_between();
        send_request(lfsa_pkg::OP_FREE,  8'd3);    idle_between();
        send_request(lfsa_pkg::OP_FREE,  8'd1);    idle_between();
        send_request(lfsa_pkg::OP_FREE,  8'd0);    idle_between();
        send_request(lfsa_pkg::OP_ALLOC, 8'h00);   idle_between();
        send_request(lfsa_pkg::OP_ALLOC, 8'h00);   idle_between();
        send_request(lfsa_pkg::OP_ALLOC, 8'h00);   idle_between();
        send_request(lfsa_pkg::OP_ALLOC, 8'h00);   idle_between();
        send_request(lfsa_pkg::OP_ALLOC, 8'h00);   idle_between();
        send_request(lfsa_pkg::OP_FREE,  8'h80);
        wait_results_done();

        // fill past the top of the table so it runs out
        run_phase(300, 97, 1'b0);
        wait_results_done();

        while (sent_cnt < 1320) begin
            kind = $urandom_range(0, 2);
            pct  = (kind == 0) ? 90 : (kind == 1) ? 15 : 50;
            run_phase($urandom_range(20, 120), pct, $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)
                wait_results_done();
        end

        wait_results_done();
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("lowest_free_slot_allocator_unit_tb: done, clean");
        else
            $display("lowest_free_slot_allocator_unit_tb: done, errors");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("lowest_free_slot_allocator_unit_tb: done, errors");
        $finish;
    end

endmodule
